// ----- hw/rtl/cpc_pkg.sv -----
// Shared types, constants and the Gaussian weight table for the column
// profile centre line block. No dependencies.
package cpc_pkg;

   // Default sizes handed down from the top level.
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int TAPS_DEF      = 19;
   localparam int MAX_PEAKS_DEF = 512;

   // Fixed field and storage widths.
   localparam int PIXEL_W     = 16;
   localparam int WIDTH_REG_W = 11;
   localparam int COL_W       = 10;
   localparam int CNT_W       = 11;
   localparam int GAUSS_W     = 14;
   localparam int FRAC_W      = 16;
   localparam logic [WIDTH_REG_W-1:0] RESET_WIDTH = 11'd1024;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] pixel_value;
      logic                      frame_end;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] center_column;
      logic [COL_W-1:0] peak_total;
      logic             no_peak;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DRAIN,
      ST_SMOOTH,
      ST_SM_FLUSH,
      ST_SM_ZERO,
      ST_MAX,
      ST_MAX_FLUSH,
      ST_PEAK,
      ST_PEAK_FLUSH,
      ST_FETCH_A,
      ST_FETCH_B,
      ST_FETCH_C,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic run;
      logic clear_en;
      logic smooth_en;
      logic zero_en;
      logic max_en;
      logic peak_en;
      logic fetch_b;
      logic fetch_c;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic frame_done;
      logic clear_last;
      logic smooth_last;
      logic max_last;
      logic peak_last;
      logic pipe_busy;
      logic rsp_busy;
   } status_type;

   // Q0.16 Gaussian weights, sigma 3, by distance from the centre tap.
   function automatic logic [GAUSS_W-1:0] gauss_weight(input logic [3:0] tap_dist);
      logic [GAUSS_W-1:0] w;
      case (tap_dist)
         4'd0:    w = 14'd8715;
         4'd1:    w = 14'd8244;
         4'd2:    w = 14'd6978;
         4'd3:    w = 14'd5285;
         4'd4:    w = 14'd3582;
         4'd5:    w = 14'd2173;
         4'd6:    w = 14'd1179;
         4'd7:    w = 14'd572;
         4'd8:    w = 14'd248;
         4'd9:    w = 14'd96;
         4'd10:   w = 14'd33;
         4'd11:   w = 14'd10;
         4'd12:   w = 14'd2;
         default: w = 14'd0;
      endcase
      return w;
   endfunction

endpackage

// ----- hw/rtl/cpc_ram.sv -----
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
module cpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] rd_data_in;

   assign rd_data_in = mem_ff[rd_addr];
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= rd_data_in;
   end

endmodule

// ----- hw/rtl/cpc_ctrl.sv -----
// Sequencing state machine for the centre line block.
// Depends on cpc_pkg.
module cpc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  cpc_pkg::status_type status,
   output cpc_pkg::cmd_type    cmd
);
   import cpc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:      if (status.clear_last) state_in = ST_RUN;
         ST_RUN:        if (status.frame_done) state_in = ST_DRAIN;
         ST_DRAIN:      state_in = ST_SMOOTH;
         ST_SMOOTH:     if (status.smooth_last) state_in = ST_SM_FLUSH;
         ST_SM_FLUSH:   if (!status.pipe_busy) state_in = ST_SM_ZERO;
         ST_SM_ZERO:    state_in = ST_MAX;
         ST_MAX:        if (status.max_last) state_in = ST_MAX_FLUSH;
         ST_MAX_FLUSH:  if (!status.pipe_busy) state_in = ST_PEAK;
         ST_PEAK:       if (status.peak_last) state_in = ST_PEAK_FLUSH;
         ST_PEAK_FLUSH: if (!status.pipe_busy) state_in = ST_FETCH_A;
         ST_FETCH_A:    state_in = ST_FETCH_B;
         ST_FETCH_B:    state_in = ST_FETCH_C;
         ST_FETCH_C:    state_in = ST_FINISH;
         ST_FINISH:     if (!status.rsp_busy) state_in = ST_CLEAR;
         default:       state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.run       = (state_ff == ST_RUN);
      cmd.clear_en  = (state_ff == ST_CLEAR);
      cmd.smooth_en = (state_ff == ST_SMOOTH);
      cmd.zero_en   = (state_ff == ST_SM_ZERO);
      cmd.max_en    = (state_ff == ST_MAX);
      cmd.peak_en   = (state_ff == ST_PEAK);
      cmd.fetch_b   = (state_ff == ST_FETCH_B);
      cmd.fetch_c   = (state_ff == ST_FETCH_C);
      cmd.finish    = (state_ff == ST_FINISH) && !status.rsp_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/cpc_datapath.sv -----
// Datapath: column counting, Gaussian smoothing MAC, maxima scan, median
// pick and the result register. Depends on cpc_pkg and cpc_ram.
module cpc_datapath #(
   parameter int MAX_WIDTH = cpc_pkg::MAX_WIDTH_DEF,
   parameter int TAPS      = cpc_pkg::TAPS_DEF,
   parameter int MAX_PEAKS = cpc_pkg::MAX_PEAKS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cpc_pkg::cmd_type                     cmd,
   output cpc_pkg::status_type                  status,
   input  logic                                 req_valid,
   input  cpc_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cpc_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [cpc_pkg::WIDTH_REG_W-1:0]      csr_write_data
);
   import cpc_pkg::*;

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int PW     = $clog2(MAX_PEAKS);
   localparam int PCW    = $clog2(MAX_PEAKS + 1);
   localparam int HALF   = (TAPS / 2 > 15) ? 15 : TAPS / 2;
   localparam int SPAN   = 2 * HALF;
   localparam int OW     = $clog2(SPAN + 1);
   localparam int IW     = CW + 3;
   localparam int PROD_W = CNT_W + GAUSS_W;
   localparam int ACC_W  = CNT_W + FRAC_W;
   localparam int CEN_W  = CW + 2;

   // ---------------- width register ----------------
   logic [WIDTH_REG_W-1:0] width_ff, width_in;
   logic [31:0]            width_wide;
   logic [WW-1:0]          w_act, w_m1;

   assign width_in   = csr_write_enable ? csr_write_data : width_ff;
   assign width_wide = 32'(width_ff);

   always_comb begin
      if (width_wide < 32'd3) begin
         w_act = WW'(3);
      end else if (width_wide > 32'(MAX_WIDTH)) begin
         w_act = WW'(MAX_WIDTH);
      end else begin
         w_act = WW'(width_wide);
      end
   end
   assign w_m1 = w_act - WW'(1);

   // ---------------- pixel counting ----------------
   logic [CW-1:0] cursor_ff, cursor_in, col, col_next;
   logic [WW-1:0] col_inc;
   logic          accept, positive;
   logic          upd_v_ff, upd_v_in, upd_pos_ff, upd_pos_in;
   logic [CW-1:0] upd_addr_ff, upd_addr_in;
   logic [CW-1:0] clr_ff, clr_in;

   assign accept   = req_valid && cmd.run;
   assign positive = !req_payload.pixel_value[PIXEL_W-1] && (req_payload.pixel_value != '0);
   assign col      = (WW'(cursor_ff) >= w_act) ? '0 : cursor_ff;
   assign col_inc  = WW'(col) + WW'(1);
   assign col_next = (col_inc >= w_act) ? '0 : col_inc[CW-1:0];

   assign cursor_in   = cmd.clear_en ? '0 : (accept ? col_next : cursor_ff);
   assign upd_v_in    = accept;
   assign upd_addr_in = col;
   assign upd_pos_in  = positive;
   assign clr_in      = cmd.clear_en ? clr_ff + CW'(1) : '0;

   // ---------------- smoothing issue ----------------
   logic [CW-1:0]          k_ff, k_in;
   logic [OW-1:0]          off_ff, off_in, tap_dist;
   logic signed [IW-1:0]   idx;
   logic                   idx_ok, tap_last;

   assign tap_last = (off_ff == OW'(SPAN));
   always_comb begin
      k_in   = '0;
      off_in = '0;
      if (cmd.smooth_en) begin
         if (tap_last) begin
            k_in = k_ff + CW'(1);
         end else begin
            k_in   = k_ff;
            off_in = off_ff + OW'(1);
         end
      end
   end

   assign idx = $signed(IW'(k_ff)) + $signed(IW'(off_ff)) + $signed(IW'(2))
              - $signed(IW'(HALF));
   assign idx_ok   = (idx >= $signed(IW'(1))) && (idx <= $signed(IW'(w_m1)));
   assign tap_dist = (off_ff >= OW'(HALF)) ? off_ff - OW'(HALF) : OW'(HALF) - off_ff;

   // ---------------- column count memory ----------------
   logic                cnt_we;
   logic [CW-1:0]       cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]    cnt_wdata, cnt_rd;

   assign cnt_we    = upd_v_ff || cmd.clear_en;
   assign cnt_waddr = cmd.clear_en ? clr_ff : upd_addr_ff;
   assign cnt_raddr = cmd.smooth_en ? idx[CW-1:0] : col;
   always_comb begin
      if (cmd.clear_en) begin
         cnt_wdata = '0;
      end else if (upd_pos_ff && (cnt_rd != '1)) begin
         cnt_wdata = cnt_rd + CNT_W'(1);
      end else begin
         cnt_wdata = cnt_rd;
      end
   end

   cpc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_WIDTH)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rd)
   );

   // ---------------- smoothing MAC pipeline ----------------
   logic                s1_v_ff, s1_v_in, s1_ok_ff, s1_first_ff, s1_last_ff;
   logic [GAUSS_W-1:0]  s1_wt_ff;
   logic [CW-1:0]       s1_k_ff;
   logic                s2_v_ff, s2_v_in, s2_first_ff, s2_last_ff;
   logic [PROD_W-1:0]   s2_prod_ff, s2_prod_in;
   logic [CW-1:0]       s2_k_ff;
   logic [ACC_W-1:0]    acc_ff, acc_in, acc_sum;

   assign s1_v_in    = cmd.smooth_en;
   assign s2_v_in    = s1_v_ff;
   assign s2_prod_in = s1_ok_ff ? PROD_W'(cnt_rd) * PROD_W'(s1_wt_ff) : '0;
   assign acc_sum    = s2_first_ff ? ACC_W'(s2_prod_ff) : acc_ff + ACC_W'(s2_prod_ff);
   assign acc_in     = s2_v_ff ? acc_sum : acc_ff;

   // ---------------- smoothed profile memory ----------------
   logic                sm_we;
   logic [CW-1:0]       sm_waddr;
   logic [CNT_W-1:0]    sm_wdata, sm_rd;
   logic [WW-1:0]       n_ff, n_in;

   assign sm_we    = (s2_v_ff && s2_last_ff) || cmd.zero_en;
   assign sm_waddr = cmd.zero_en ? w_m1[CW-1:0] : s2_k_ff;
   assign sm_wdata = cmd.zero_en ? '0 : acc_sum[FRAC_W +: CNT_W];

   cpc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_WIDTH)) u_smooth (
      .clock   (clock),
      .wr_en   (sm_we),
      .wr_addr (sm_waddr),
      .wr_data (sm_wdata),
      .rd_addr (n_ff[CW-1:0]),
      .rd_data (sm_rd)
   );

   // ---------------- profile scans ----------------
   logic                scan_en;
   logic                r1_v_ff, r1_v_in, r1_peak_ff, r1_pad_ff;
   logic [WW-1:0]       r1_n_ff;
   logic [CNT_W-1:0]    pmax_ff, pmax_in;
   logic [CNT_W-1:0]    cur_ff, cur_in, prv_ff, prv_in, nxt;
   logic [CW-1:0]       pstart_ff, pstart_in, e_idx, st, mid;
   logic [CW:0]         mid_sum;
   logic                pvalid_ff, pvalid_in, rising_ff, rising_in;
   logic [PCW-1:0]      pcount_ff, pcount_in;
   logic                push;

   assign scan_en = cmd.max_en || cmd.peak_en;
   assign n_in    = scan_en ? n_ff + WW'(1) : '0;
   assign r1_v_in = scan_en;
   assign nxt     = r1_pad_ff ? cur_ff : sm_rd;
   assign e_idx   = CW'(r1_n_ff - WW'(1));
   assign st      = pvalid_ff ? pstart_ff : e_idx;
   assign mid_sum = (CW+1)'(st) + (CW+1)'(e_idx);
   assign mid     = mid_sum[CW:1];

   always_comb begin
      pmax_in   = pmax_ff;
      cur_in    = cur_ff;
      prv_in    = prv_ff;
      pstart_in = pstart_ff;
      pvalid_in = pvalid_ff;
      rising_in = rising_ff;
      pcount_in = pcount_ff;
      push      = 1'b0;
      if (cmd.smooth_en) begin
         pmax_in = '0;
      end
      if (cmd.max_en) begin
         pvalid_in = 1'b0;
         rising_in = 1'b0;
         pcount_in = '0;
         pstart_in = '0;
      end
      if (r1_v_ff && !r1_peak_ff) begin
         if (sm_rd > pmax_ff) begin
            pmax_in = sm_rd;
         end
      end
      if (r1_v_ff && r1_peak_ff) begin
         if (r1_n_ff == '0) begin
            cur_in = sm_rd;
            prv_in = sm_rd;
         end else begin
            prv_in = cur_ff;
            cur_in = nxt;
            if (cur_ff < nxt) begin
               pvalid_in = 1'b0;
               rising_in = 1'b1;
            end else if (cur_ff == nxt) begin
               if (!pvalid_ff) begin
                  pstart_in = e_idx;
                  pvalid_in = 1'b1;
               end
            end else if (cur_ff < prv_ff) begin
               pvalid_in = 1'b0;
            end else begin
               pstart_in = st;
               if (rising_ff) begin
                  // plateau values all equal the current one
                  if ((cur_ff > (pmax_ff >> 1)) && (pcount_ff < PCW'(MAX_PEAKS))) begin
                     push      = 1'b1;
                     pcount_in = pcount_ff + PCW'(1);
                  end
                  rising_in = 1'b0;
               end
               pvalid_in = 1'b0;
            end
         end
      end
   end

   // ---------------- peak list and median ----------------
   logic [PW-1:0]  half_idx, pk_b, pk_raddr;
   logic [CW-1:0]  pk_rd, pa_ff, pa_in, pb_ff, pb_in;

   assign half_idx = PW'(pcount_ff >> 1);
   assign pk_b     = pcount_ff[0] ? half_idx : half_idx - PW'(1);
   assign pk_raddr = cmd.fetch_b ? pk_b : half_idx;
   assign pa_in    = cmd.fetch_b ? pk_rd : pa_ff;
   assign pb_in    = cmd.fetch_c ? pk_rd : pb_ff;

   cpc_ram #(.WIDTH(CW), .DEPTH(MAX_PEAKS)) u_peaks (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (pcount_ff[PW-1:0]),
      .wr_data (mid),
      .rd_addr (pk_raddr),
      .rd_data (pk_rd)
   );

   logic [CW:0]      pair;
   logic [CEN_W-1:0] cen_raw, cen;
   logic             none;

   assign none    = (pcount_ff == '0);
   assign pair    = (CW+1)'(pa_ff) + (CW+1)'(pb_ff);
   assign cen_raw = none ? CEN_W'(w_act >> 1) : CEN_W'(pair[CW:1]) + CEN_W'(2);
   assign cen     = (cen_raw > CEN_W'(w_m1)) ? CEN_W'(w_m1) : cen_raw;

   // ---------------- result register ----------------
   logic    rsp_v_ff, rsp_v_in;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_v_in = rsp_v_ff;
      rsp_in   = rsp_ff;
      if (rsp_v_ff && rsp_ready) begin
         rsp_v_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_v_in             = 1'b1;
         rsp_in.center_column = COL_W'(cen);
         rsp_in.peak_total    = COL_W'(pcount_ff);
         rsp_in.no_peak       = none;
      end
   end

   assign rsp_valid   = rsp_v_ff;
   assign rsp_payload = rsp_ff;

   // ---------------- status ----------------
   always_comb begin
      status             = '0;
      status.frame_done  = accept && req_payload.frame_end;
      status.clear_last  = cmd.clear_en && (clr_ff == CW'(MAX_WIDTH - 1));
      status.smooth_last = cmd.smooth_en && tap_last && (WW'(k_ff) == w_act - WW'(2));
      status.max_last    = cmd.max_en && (n_ff == w_m1);
      status.peak_last   = cmd.peak_en && (n_ff == w_act);
      status.pipe_busy   = s1_v_ff || s2_v_ff || r1_v_ff;
      status.rsp_busy    = rsp_v_ff;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         cursor_ff <= '0;
         upd_v_ff  <= 1'b0;
         clr_ff    <= '0;
         k_ff      <= '0;
         off_ff    <= '0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         n_ff      <= '0;
         r1_v_ff   <= 1'b0;
         pmax_ff   <= '0;
         pvalid_ff <= 1'b0;
         rising_ff <= 1'b0;
         pcount_ff <= '0;
         pstart_ff <= '0;
         rsp_v_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         cursor_ff <= cursor_in;
         upd_v_ff  <= upd_v_in;
         clr_ff    <= clr_in;
         k_ff      <= k_in;
         off_ff    <= off_in;
         s1_v_ff   <= s1_v_in;
         s2_v_ff   <= s2_v_in;
         n_ff      <= n_in;
         r1_v_ff   <= r1_v_in;
         pmax_ff   <= pmax_in;
         pvalid_ff <= pvalid_in;
         rising_ff <= rising_in;
         pcount_ff <= pcount_in;
         pstart_ff <= pstart_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      upd_addr_ff <= upd_addr_in;
      upd_pos_ff  <= upd_pos_in;
      s1_ok_ff    <= idx_ok;
      s1_wt_ff    <= gauss_weight(4'(tap_dist));
      s1_first_ff <= (off_ff == '0);
      s1_last_ff  <= tap_last;
      s1_k_ff     <= k_ff;
      s2_prod_ff  <= s2_prod_in;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_k_ff     <= s1_k_ff;
      acc_ff      <= acc_in;
      r1_peak_ff  <= cmd.peak_en;
      r1_pad_ff   <= (n_ff == w_act);
      r1_n_ff     <= n_ff;
      cur_ff      <= cur_in;
      prv_ff      <= prv_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ----- hw/rtl/column_profile_centerline.sv -----
// Column profile centre line finder: pixels in, one centre column per frame.
// Pixels are taken one a cycle while the block is counting; after the frame-end
// beat the counts are smoothed by the single multiply-accumulate unit, the
// profile is scanned for its maximum and for peaks, and the result is loaded.
// Reset is synchronous; a clearing pass over the whole count memory follows
// reset and every result, during which no pixel beat is taken.
module column_profile_centerline #(
   parameter int MAX_WIDTH = cpc_pkg::MAX_WIDTH_DEF,
   parameter int TAPS      = cpc_pkg::TAPS_DEF,
   parameter int MAX_PEAKS = cpc_pkg::MAX_PEAKS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel stream
   input  logic                             req_valid,
   output logic                             req_ready,
   input  cpc_pkg::req_type                 req_payload,
   // one result beat per frame
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cpc_pkg::rsp_type                 rsp_payload,
   // width register
   input  logic                             csr_write_enable,
   input  logic [cpc_pkg::WIDTH_REG_W-1:0]  csr_write_data
);
   import cpc_pkg::*;

   // Command and status between the sequencer and the datapath.
   cmd_type    cmd;
   status_type status;

   // Sequencer: clear, take pixels, smooth, scan for the maximum, scan for
   // plateau-centred peaks, fetch the middle peaks, load the result.
   cpc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Datapath: three memories (column counts, smoothed profile, peak list),
   // one multiplier in the smoothing pipeline and the result register, which
   // holds a finished beat while the next frame is already being counted.
   cpc_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .TAPS      (TAPS),
      .MAX_PEAKS (MAX_PEAKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_valid        (req_valid),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Take pixel beats only while counting.
   assign req_ready = cmd.run;

endmodule

// ----- hw/rtl/cpc_checker.sv -----
// Port-level checks for the centre line block, bound to the top level.
// Depends on cpc_pkg.
module cpc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input cpc_pkg::req_type                req_payload,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input cpc_pkg::rsp_type                rsp_payload,
   input logic                            csr_write_enable,
   input logic [cpc_pkg::WIDTH_REG_W-1:0] csr_write_data
);

   // Hold a stalled result beat.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat dropped or changed while stalled");

   // Stop taking pixels once the frame closes.
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.frame_end |=> !req_ready)
      else $error("pixel taken right after frame end");

   // Come out of reset clearing, with no result pending.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block active straight after reset");

   // Raise a result only while pixel intake is closed.
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready)
      else $error("result raised while pixels are being taken");

   // Report no maxima only with a zero count.
   a_no_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.no_peak |-> rsp_payload.peak_total == '0)
      else $error("no_peak with a non-zero peak count");

endmodule

bind column_profile_centerline cpc_checker u_cpc_checker (.*);

// ----- verif/column_profile_centerline_tb.sv -----
// Self-checking testbench for column_profile_centerline: drives pixel frames,
// predicts each frame's centre column and compares every result beat.
// Depends on cpc_pkg and the column_profile_centerline RTL.

class centre_scoreboard;
   int unsigned         width_reg;
   int unsigned         counts[1024];
   int unsigned         cursor;
   cpc_pkg::rsp_type    pending[$];
   int                  errors;

   function new();
      width_reg = 1024;
      cursor    = 0;
      errors    = 0;
      foreach (counts[i]) counts[i] = 0;
   endfunction

   function int unsigned gauss(int unsigned d);
      int unsigned g[13] = '{8715, 8244, 6978, 5285, 3582, 2173, 1179, 572,
                             248, 96, 33, 10, 2};
      return (d < 13) ? g[d] : 0;
   endfunction

   function int unsigned span();
      if (width_reg < 3) return 3;
      if (width_reg > 1024) return 1024;
      return width_reg;
   endfunction

   function void note_pixel(cpc_pkg::req_type beat);
      int unsigned w, pmax, pcnt, pstart, cur, nxt, prv, mid, centre;
      int unsigned acc, idx;
      int unsigned sm[1024];
      int unsigned plist[512];
      bit rising, pvalid;
      cpc_pkg::rsp_type r;
      w = span();
      if (cursor >= w) cursor = 0;
      if (beat.pixel_value > 0 && counts[cursor] < 2047) counts[cursor]++;
      cursor++;
      if (cursor >= w) cursor = 0;
      if (!beat.frame_end) return;
      // smooth, centred two columns to the right
      for (int k = 0; k < w - 1; k++) begin
         acc = 0;
         for (int j = -9; j <= 9; j++) begin
            idx = k + 2 + j;
            if (k + 2 + j >= 1 && k + 2 + j <= w - 1)
               acc += counts[idx] * gauss(j < 0 ? -j : j);
         end
         sm[k] = (acc >> 16) & 16'hFFFF;
      end
      sm[w-1] = 0;
      pmax = 0;
      for (int i = 0; i < w; i++) if (sm[i] > pmax) pmax = sm[i];
      pcnt = 0; pstart = 0; pvalid = 0; rising = 0;
      for (int i = 0; i < w; i++) begin
         cur = sm[i];
         nxt = (i + 1 < w) ? sm[i+1] : cur;
         prv = (i > 0) ? sm[i-1] : cur;
         if (cur < nxt) begin
            pvalid = 0; rising = 1;
         end else if (cur == nxt) begin
            if (!pvalid) begin
               pstart = i; pvalid = 1;
            end
         end else if (cur < prv) begin
            pvalid = 0;
         end else begin
            if (!pvalid) pstart = i;
            mid = (pstart + i) / 2;
            if (rising) begin
               if (sm[mid] > pmax / 2 && pcnt < 512) begin
                  plist[pcnt] = mid; pcnt++;
               end
               rising = 0;
            end
            pvalid = 0;
         end
      end
      if (pcnt == 0) centre = w / 2;
      else if (pcnt % 2 == 0)
         centre = 2 + (plist[pcnt/2] + plist[pcnt/2-1]) / 2;
      else centre = 2 + plist[pcnt/2];
      if (centre > w - 1) centre = w - 1;
      r.center_column = centre[9:0];
      r.peak_total    = pcnt[9:0];
      r.no_peak       = (pcnt == 0);
      pending.insert(pending.size(), r);
      foreach (counts[i]) counts[i] = 0;
      cursor = 0;
   endfunction

   task report(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task check_result(cpc_pkg::rsp_type got);
      cpc_pkg::rsp_type want;
      if (pending.size() == 0) begin
         report("unexpected beat", got, 0);
         return;
      end
      want = pending.pop_front();
      if (got.center_column != want.center_column)
         report("center_column", got.center_column, want.center_column);
      if (got.peak_total != want.peak_total)
         report("peak_total", got.peak_total, want.peak_total);
      if (got.no_peak != want.no_peak)
         report("no_peak", got.no_peak, want.no_peak);
   endtask
endclass

module column_profile_centerline_tb;
   import cpc_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_payload;
   logic        csr_write_enable = 0;
   logic [WIDTH_REG_W-1:0] csr_write_data = '0;

   centre_scoreboard board = new();

   // idling percentages for each side, changed by the stimulus phases
   int          send_idle = 0;
   int          recv_stall = 0;
   int          hold_off = 0;     // cycles of forced receiver back-pressure
   longint      cycle = 0;
   localparam longint CYCLE_LIMIT = 64'd40_000_000;

   column_profile_centerline dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   // Watchdog: fail the run on a hang.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > CYCLE_LIMIT) begin
         $display("** column_profile_centerline: FAILED **");
         $finish;
      end
   end

   // Receiver: check each accepted beat, then pick next cycle's ready.
   // A long hold-off is counted here so the block backs up into its input.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_payload);
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   // Offer one pixel beat; hold it until taken, with random idle gaps first.
   // Valid stays up after a beat so back-to-back beats need no gap.
   task automatic send_pixel(input logic signed [15:0] pix, input logic fe);
      req_type beat;
      beat.pixel_value = pix;
      beat.frame_end   = fe;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid   <= 1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_pixel(beat);
   endtask

   // Drain every expected beat plus a latency margin so the block is idle.
   task automatic settle();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (1024 * 20 + 2200) @(posedge clock);
   endtask

   task automatic write_width(input int unsigned w);
      settle();
      csr_write_enable <= 1;
      csr_write_data   <= w[10:0];
      @(posedge clock);
      csr_write_enable <= 0;
      board.width_reg = w & 11'h7FF;
   endtask

   // Random pixel: mostly a bright stripe around a chosen column, else noise.
   function automatic logic signed [15:0] pick_pixel(int unsigned col, int unsigned ctr,
                                                    int unsigned spread);
      int unsigned d;
      d = (col > ctr) ? col - ctr : ctr - col;
      case ($urandom_range(9))
         0:       return 16'($urandom);
         1:       return -$signed({1'b0, 15'($urandom)});
         default: return (d <= spread) ? 16'($urandom_range(32767, 1))
                                       : (($urandom_range(3) == 0) ? 16'sd1 : 16'sd0);
      endcase
   endfunction

   // One frame of random content; the frame-end beat lands at a random row end
   // or, at random and for frames over 40 beats, part way through.
   task automatic random_frame(input int unsigned w, input int unsigned rows);
      int unsigned ctr, spread, n;
      ctr    = $urandom_range(w - 1);
      spread = $urandom_range(w / 2);
      n      = w * rows;
      if ($urandom_range(4) == 0) n = $urandom_range(n, 1);
      if (n > 40) n = $urandom_range(40, 20);
      for (int i = 0; i < n; i++)
         send_pixel(pick_pixel(i % w, ctr, spread), i == n - 1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;

      // Directed: smallest width, extremes of the pixel field, empty frame.
      write_width(3);
      send_pixel(16'sh7FFF, 0); send_pixel(-16'sd32768, 0); send_pixel(16'sd1, 0);
      send_pixel(16'sd0, 0);    send_pixel(-16'sd1, 0);     send_pixel(16'sd5, 1);
      send_pixel(16'sd0, 1);    // no counts: no maxima, width/2
      // Width below range acts as three; one frame of a single row.
      write_width(0);
      send_pixel(16'sd0, 0); send_pixel(16'sd9, 0); send_pixel(16'sd0, 1);
      // Above range acts as the maximum; a short sparse partial row.
      write_width(2047);
      for (int i = 0; i < 40; i++) send_pixel((i == 30) ? 16'sd3 : 16'sd0, i == 39);
      // Flat plateau and two peaks at a narrow width.
      write_width(8);
      for (int i = 0; i < 16; i++) send_pixel((i % 8 == 1 || i % 8 == 6) ? 16'sd1 : 16'sd0,
                                              i == 15);
      // Cursor past width after a width change mid frame.
      write_width(40);
      for (int i = 0; i < 30; i++) send_pixel(16'sd1, 0);
      write_width(10);
      send_pixel(16'sd1, 0); send_pixel(16'sd1, 1);

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 54) : 0;
         recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 54) : 0;
         for (int f = 0; f < 6; f++) begin
            int unsigned w;
            w = (f == 0 && ph == 0) ? 1024 : $urandom_range(24, 3);
            if (f == 5) w = $urandom_range(2047, 0);
            write_width(w);
            // Long hold-off: keep sending frames so the result register
            // fills and the pixel input stalls behind it.
            if (ph == 2 && f == 1) begin
               hold_off = 8000;
               random_frame(board.span(), $urandom_range(8, 1));
               random_frame(board.span(), $urandom_range(8, 1));
            end
            random_frame(board.span() > 40 ? board.span() : board.span(),
                         board.span() > 64 ? 1 : $urandom_range(8, 1));
         end
      end

      // Heavy counts: many rows at a narrow width.
      write_width(4);
      for (int i = 0; i < 120; i++) send_pixel(16'sd100, i == 119);

      settle();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("** column_profile_centerline: PASSED **");
      end else begin
         $display("** column_profile_centerline: FAILED **");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/cpc_pkg.sv
hw/rtl/cpc_ram.sv
hw/rtl/cpc_ctrl.sv
hw/rtl/cpc_datapath.sv
hw/rtl/column_profile_centerline.sv
hw/rtl/cpc_checker.sv
verif/column_profile_centerline_tb.sv
